// ----- hw/rtl/vario_tone_beeper_macros.svh -----
// ---------------------------------------------------------------------------
// vario tone beeper assertion macros
// shared assertion forms for the tone beeper rtl
// ---------------------------------------------------------------------------
`ifndef VARIO_TONE_BEEPER_MACROS_SVH
`define VARIO_TONE_BEEPER_MACROS_SVH

// same-cycle implication, disabled during reset
`define VTB_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtb check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define VTB_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtb check failed: next-cycle implication");

`endif

// ----- hw/rtl/vtb_pkg.sv -----
// ---------------------------------------------------------------------------
// vtb_pkg
// widths, codes, tables and shared types of the vario tone beeper
// ---------------------------------------------------------------------------
`default_nettype none

package vtb_pkg;

  // field widths
  localparam int RATE_W     = 16;
  localparam int HZ_W       = 13;
  localparam int TH_W       = 14;
  localparam int CNT_W      = 6;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // interpolation datapath widths
  localparam int EXT_W  = 17;
  localparam int OPA_W  = EXT_W;
  localparam int OPB_W  = 15;
  localparam int DEN_W  = EXT_W;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int QUOT_W = PROD_W + 1;
  localparam int SUM_W  = QUOT_W + 1;

  // full-scale climb rate, cm/s
  localparam int MAX_RATE_CPS = 1000;
  localparam logic signed [EXT_W-1:0] MAX_RATE_X = EXT_W'(MAX_RATE_CPS);

  typedef enum logic [MODE_W-1:0] {
    MODE_QUIET  = 2'd0,
    MODE_ZEROES = 2'd1,
    MODE_CLIMB  = 2'd2,
    MODE_SINK   = 2'd3
  } tone_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SINK_TH    = 3'd0,
    REG_CLIMB_TH   = 3'd1,
    REG_ZEROES_TH  = 3'd2,
    REG_CROSS_RATE = 3'd3,
    REG_MIN_FREQ   = 3'd4,
    REG_MAX_FREQ   = 3'd5,
    REG_CROSS_FREQ = 3'd6
  } reg_index_t;

  // register reset values
  localparam logic signed [TH_W-1:0] RST_SINK_TH   = TH_W'(-250);
  localparam logic [HZ_W-1:0]        RST_CLIMB_TH  = HZ_W'(50);
  localparam logic signed [TH_W-1:0] RST_ZEROES_TH = TH_W'(5);
  localparam logic [HZ_W-1:0]        RST_CROSS_RATE = HZ_W'(400);
  localparam logic [HZ_W-1:0]        RST_MIN_FREQ  = HZ_W'(200);
  localparam logic [HZ_W-1:0]        RST_MAX_FREQ  = HZ_W'(3200);
  localparam logic [HZ_W-1:0]        RST_CROSS_FREQ = HZ_W'(1000);

  // beep timing, ticks
  localparam logic [CNT_W-1:0] WARBLE_TICKS  = CNT_W'(8);
  localparam logic [CNT_W-1:0] SINK_PERIOD   = CNT_W'(40);
  localparam logic [CNT_W-1:0] SINK_ON       = CNT_W'(30);
  localparam logic [CNT_W-1:0] ZEROES_PERIOD = CNT_W'(30);
  localparam logic [CNT_W-1:0] ZEROES_ON     = CNT_W'(5);

  // tone offsets, Hz
  localparam logic [OPB_W-1:0] SINK_OFFSET_HZ = OPB_W'(600);
  localparam logic [HZ_W-1:0]  SINK_FALL_HZ   = HZ_W'(20);

  // warble tables, indexed by tick modulo 8
  localparam int WARBLE_STEPS = 8;
  localparam logic [HZ_W-1:0] WARBLE_HI [WARBLE_STEPS] = '{
    13'd400, 13'd800, 13'd1200, 13'd1600, 13'd2000, 13'd1600, 13'd1200, 13'd800
  };
  localparam logic [HZ_W-1:0] WARBLE_LO [WARBLE_STEPS] = '{
    13'd4000, 13'd3500, 13'd3000, 13'd2500, 13'd2000, 13'd1500, 13'd1000, 13'd500
  };

  // climb beep timing per m/s
  localparam int CLIMB_STEPS = 10;
  localparam int CLIMB_IDX_W = 4;
  localparam int RATE_STEP   = 100;
  localparam logic [CNT_W-1:0] CLIMB_PERIOD [CLIMB_STEPS] = '{
    6'd16, 6'd14, 6'd12, 6'd10, 6'd9, 6'd8, 6'd7, 6'd6, 6'd5, 6'd4
  };
  localparam logic [CNT_W-1:0] CLIMB_ON [CLIMB_STEPS] = '{
    6'd10, 6'd9, 6'd8, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd2
  };

  // rate / 100, clamped to the table range
  function automatic logic [CLIMB_IDX_W-1:0] climb_index(
    input logic signed [RATE_W-1:0] rate
  );
    logic [CLIMB_IDX_W-1:0] idx;
    logic signed [RATE_W-1:0] step_rate;
    idx = '0;
    for (int k = 1; k < CLIMB_STEPS; k++) begin
      step_rate = RATE_W'(k * RATE_STEP);
      if (rate >= step_rate) begin
        idx = CLIMB_IDX_W'(k);
      end
    end
    return idx;
  endfunction

  // request to the serial multiply-divide unit: a * b / den
  typedef struct packed {
    logic                    start;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
    logic signed [DEN_W-1:0] den;
  } md_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } md_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vtb_rate_if.sv -----
// ---------------------------------------------------------------------------
// vtb_rate_if
// valid/ready channel carrying one climb rate word per tick
// ---------------------------------------------------------------------------
`default_nettype none

interface vtb_rate_if;
  logic                               valid;
  logic                               ready;
  logic signed [vtb_pkg::RATE_W-1:0] climb_rate_cps;

  modport source (output valid, output climb_rate_cps, input ready);
  modport sink   (input valid, input climb_rate_cps, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vtb_tone_if.sv -----
// ---------------------------------------------------------------------------
// vtb_tone_if
// valid/ready channel carrying one speaker tone word per tick
// ---------------------------------------------------------------------------
`default_nettype none

interface vtb_tone_if;
  logic                         valid;
  logic                         ready;
  logic [vtb_pkg::HZ_W-1:0]     tone_hz;
  logic                         tone_update;
  logic [vtb_pkg::MODE_W-1:0]   mode;

  modport source (output valid, output tone_hz, output tone_update, output mode,
                  input ready);
  modport sink   (input valid, input tone_hz, input tone_update, input mode,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vtb_muldiv.sv -----
// ---------------------------------------------------------------------------
// vtb_muldiv
// bit-serial signed a * b / den, quotient truncated toward zero
// ---------------------------------------------------------------------------
`default_nettype none

module vtb_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  vtb_pkg::md_req_t  req,
  output vtb_pkg::md_rsp_t  rsp
);

  localparam int OpaW   = vtb_pkg::OPA_W;
  localparam int OpbW   = vtb_pkg::OPB_W;
  localparam int DenW   = vtb_pkg::DEN_W;
  localparam int ProdW  = vtb_pkg::PROD_W;
  localparam int QuotW  = vtb_pkg::QUOT_W;
  localparam int StepW  = $clog2(ProdW);
  localparam logic [StepW-1:0] MulLast = StepW'(OpbW - 1);
  localparam logic [StepW-1:0] DivLast = StepW'(ProdW - 1);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_FIN  = 4'b1000
  } md_state_t;

  md_state_t          state;
  logic [OpaW-1:0]    mcand;
  logic [OpaW:0]      hi;
  logic [OpbW-1:0]    lo;
  logic [DenW-1:0]    dvs;
  logic [DenW-1:0]    rem;
  logic [ProdW-1:0]   quo;
  logic               neg;
  logic               dzero;
  logic [StepW-1:0]   step;
  logic [QuotW-1:0]   quot;
  logic               done;

  logic [OpaW-1:0]    mag_a;
  logic [OpbW-1:0]    mag_b;
  logic [DenW-1:0]    mag_den;
  logic [OpaW:0]      psum;
  logic [DenW:0]      trial;
  logic [DenW:0]      diff;
  logic               fits;

  assign mag_a   = req.a[OpaW-1]   ? OpaW'(-req.a)   : OpaW'(req.a);
  assign mag_b   = req.b[OpbW-1]   ? OpbW'(-req.b)   : OpbW'(req.b);
  assign mag_den = req.den[DenW-1] ? DenW'(-req.den) : DenW'(req.den);

  // shift-add step: one multiplier bit per cycle
  assign psum  = hi + (lo[0] ? {1'b0, mcand} : '0);
  // restoring step: one quotient bit per cycle
  assign trial = {rem, quo[ProdW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (req.start) begin
            mcand <= mag_a;
            hi    <= '0;
            lo    <= mag_b;
            dvs   <= mag_den;
            neg   <= req.a[OpaW-1] ^ req.b[OpbW-1] ^ req.den[DenW-1];
            dzero <= (req.den == '0);
            step  <= '0;
            state <= MD_MUL;
          end
        end
        MD_MUL: begin
          hi   <= {1'b0, psum[OpaW:1]};
          lo   <= {psum[0], lo[OpbW-1:1]};
          step <= step + 1'b1;
          if (step == MulLast) begin
            quo   <= {psum, lo[OpbW-1:1]};
            rem   <= '0;
            step  <= '0;
            state <= MD_DIV;
          end
        end
        MD_DIV: begin
          rem  <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
          quo  <= {quo[ProdW-2:0], fits};
          step <= step + 1'b1;
          if (step == DivLast) begin
            state <= MD_FIN;
          end
        end
        MD_FIN: begin
          if (dzero) begin
            quot <= '0;
          end else if (neg) begin
            quot <= QuotW'(0) - {1'b0, quo};
          end else begin
            quot <= {1'b0, quo};
          end
          done  <= 1'b1;
          state <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

// ----- hw/rtl/vario_tone_beeper.sv -----
// ---------------------------------------------------------------------------
// vario_tone_beeper
// variometer audio: climb rate per tick in, speaker tone per tick out
// ---------------------------------------------------------------------------
//
//   channel    dir  handshake     word
//   rate_in    in   valid/ready   climb_rate_cps, cm/s signed
//   tone_out   out  valid/ready   tone_hz, tone_update, mode
//   cfg_*      in   write enable  cfg_index selects, cfg_data is the value
//
// a tick with no interpolation (beep continues, warble or quiet start) goes
// through ST_EVAL and ST_PUT from accept to output word
// a beep start with an interpolated tone also waits in ST_WAIT for 15 multiply steps
// and 32 divide steps in the bit-serial multiply-divide unit, plus setup
// one tick is worked on at a time; the next word is accepted while the
// previous output word still waits in the output register
// reset is synchronous, clears state and loads the register defaults
// a stalled output only holds the block once the next result is done
// ---------------------------------------------------------------------------
`default_nettype none
`include "vario_tone_beeper_macros.svh"

module vario_tone_beeper (
  input  logic                               clk,
  input  logic                               rst,
  vtb_rate_if.sink                           rate_in,
  vtb_tone_if.source                         tone_out,
  input  logic                               cfg_we,
  input  logic [vtb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vtb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RateW = vtb_pkg::RATE_W;
  localparam int HzW   = vtb_pkg::HZ_W;
  localparam int ThW   = vtb_pkg::TH_W;
  localparam int CntW  = vtb_pkg::CNT_W;
  localparam int ExtW  = vtb_pkg::EXT_W;
  localparam int OpbW  = vtb_pkg::OPB_W;
  localparam int QuotW = vtb_pkg::QUOT_W;
  localparam int SumW  = vtb_pkg::SUM_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,   // waiting for a rate word
    ST_EVAL = 4'b0010,   // decide beep start, update counters
    ST_WAIT = 4'b0100,   // interpolation running in the muldiv unit
    ST_PUT  = 4'b1000    // hand the result to the output register
  } state_t;

  state_t state;

  // configuration registers
  logic signed [ThW-1:0] sink_threshold;
  logic [HzW-1:0]        climb_threshold;
  logic signed [ThW-1:0] zeroes_threshold;
  logic [HzW-1:0]        crossover_rate;
  logic [HzW-1:0]        min_freq;
  logic [HzW-1:0]        max_freq;
  logic [HzW-1:0]        crossover_freq;

  // beep state
  logic signed [RateW-1:0] rate;
  logic signed [RateW-1:0] latched_rate;
  logic [HzW-1:0]          playing_hz;
  logic [CntW-1:0]         period_left;
  logic [CntW-1:0]         on_ticks;
  logic [CntW-1:0]         tick_count;
  vtb_pkg::tone_mode_t     tone_mode;
  logic                    upd;
  logic [HzW-1:0]          base_hz;

  // output register
  logic                        out_valid;
  logic [HzW-1:0]              out_hz;
  logic                        out_upd;
  logic [vtb_pkg::MODE_W-1:0]  out_mode;

  vtb_pkg::md_req_t md_req;
  vtb_pkg::md_rsp_t md_rsp;

  // ------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sink_threshold   <= vtb_pkg::RST_SINK_TH;
      climb_threshold  <= vtb_pkg::RST_CLIMB_TH;
      zeroes_threshold <= vtb_pkg::RST_ZEROES_TH;
      crossover_rate   <= vtb_pkg::RST_CROSS_RATE;
      min_freq         <= vtb_pkg::RST_MIN_FREQ;
      max_freq         <= vtb_pkg::RST_MAX_FREQ;
      crossover_freq   <= vtb_pkg::RST_CROSS_FREQ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vtb_pkg::REG_SINK_TH:    sink_threshold   <= cfg_data;
        vtb_pkg::REG_CLIMB_TH:   climb_threshold  <= cfg_data[HzW-1:0];
        vtb_pkg::REG_ZEROES_TH:  zeroes_threshold <= cfg_data;
        vtb_pkg::REG_CROSS_RATE: crossover_rate   <= cfg_data[HzW-1:0];
        vtb_pkg::REG_MIN_FREQ:   min_freq         <= cfg_data[HzW-1:0];
        vtb_pkg::REG_MAX_FREQ:   max_freq         <= cfg_data[HzW-1:0];
        vtb_pkg::REG_CROSS_FREQ: crossover_freq   <= cfg_data[HzW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------------------
  // everything compared on a common 17-bit signed scale
  // ------------------------------------------------------------------
  logic signed [ExtW-1:0] r_x, lat_x, sink_x, climb_x, zeroes_x, cross_x;

  assign r_x      = {{(ExtW-RateW){rate[RateW-1]}}, rate};
  assign lat_x    = {{(ExtW-RateW){latched_rate[RateW-1]}}, latched_rate};
  assign sink_x   = {{(ExtW-ThW){sink_threshold[ThW-1]}}, sink_threshold};
  assign zeroes_x = {{(ExtW-ThW){zeroes_threshold[ThW-1]}}, zeroes_threshold};
  assign climb_x  = {{(ExtW-HzW){1'b0}}, climb_threshold};
  assign cross_x  = {{(ExtW-HzW){1'b0}}, crossover_rate};

  logic start_beep, is_sink, sink_warble, is_climb, climb_warble;
  logic above_cross, is_zeroes, lat_hi_warble, lat_lo_warble;

  // new beep when the period ran out or the climb threshold was just crossed
  assign start_beep    = (period_left == '0) || ((r_x >= climb_x) && (lat_x < climb_x));
  assign is_sink       = (r_x <= sink_x);
  assign sink_warble   = (r_x <= -vtb_pkg::MAX_RATE_X);
  assign is_climb      = (r_x >= climb_x);
  assign climb_warble  = (r_x >= vtb_pkg::MAX_RATE_X);
  assign above_cross   = (r_x > cross_x);
  assign is_zeroes     = (r_x >= zeroes_x);
  assign lat_hi_warble = (lat_x >= vtb_pkg::MAX_RATE_X);
  assign lat_lo_warble = (lat_x <= -vtb_pkg::MAX_RATE_X);

  logic [vtb_pkg::CLIMB_IDX_W-1:0] climb_idx;
  assign climb_idx = vtb_pkg::climb_index(rate);

  // interpolation operands: base + a * b / den
  logic [OpbW-1:0] min_b, max_b, cf_b, half_max_b;
  assign min_b      = {{(OpbW-HzW){1'b0}}, min_freq};
  assign max_b      = {{(OpbW-HzW){1'b0}}, max_freq};
  assign cf_b       = {{(OpbW-HzW){1'b0}}, crossover_freq};
  assign half_max_b = {{(OpbW-HzW+1){1'b0}}, max_freq[HzW-1:1]};

  // sink band: from max/2 at full-scale sink toward min + 600 at threshold
  logic signed [ExtW-1:0] a_sink, den_sink;
  logic signed [OpbW-1:0] b_sink;
  assign a_sink   = r_x + vtb_pkg::MAX_RATE_X;
  assign b_sink   = min_b + vtb_pkg::SINK_OFFSET_HZ - half_max_b;
  assign den_sink = sink_x + vtb_pkg::MAX_RATE_X;

  // octave band: above the crossover rate up to full scale
  logic signed [ExtW-1:0] a_oct, den_oct;
  logic signed [OpbW-1:0] b_oct;
  assign a_oct   = r_x - cross_x;
  assign b_oct   = max_b - cf_b;
  assign den_oct = vtb_pkg::MAX_RATE_X - cross_x;

  // decade band: zeroes threshold up to crossover; zero span gives term 0
  logic signed [ExtW-1:0] a_dec, den_dec;
  logic signed [OpbW-1:0] b_dec;
  assign a_dec   = r_x - zeroes_x;
  assign b_dec   = cf_b - min_b;
  assign den_dec = cross_x - zeroes_x;

  // ------------------------------------------------------------------
  // tick evaluation
  // ------------------------------------------------------------------
  logic                   run_div;
  logic signed [ExtW-1:0] op_a, op_den;
  logic signed [OpbW-1:0] op_b;
  logic [HzW-1:0]         op_base;
  vtb_pkg::tone_mode_t    mode_next;
  logic [CntW-1:0]        period_next, on_next, tick_next;
  logic [HzW-1:0]         hz_next;
  logic                   upd_next;

  always_comb begin
    run_div     = 1'b0;
    op_a        = a_dec;
    op_b        = b_dec;
    op_den      = den_dec;
    op_base     = min_freq;
    mode_next   = tone_mode;
    period_next = period_left - 1'b1;
    on_next     = on_ticks;
    tick_next   = tick_count + 1'b1;
    hz_next     = playing_hz;
    upd_next    = 1'b0;
    if (start_beep) begin
      // every beep start rewrites the speaker, quiet included
      tick_next = '0;
      upd_next  = 1'b1;
      hz_next   = '0;
      if (is_sink) begin
        mode_next = vtb_pkg::MODE_SINK;
        if (sink_warble) begin
          period_next = vtb_pkg::WARBLE_TICKS;
          on_next     = vtb_pkg::WARBLE_TICKS;
          hz_next     = vtb_pkg::WARBLE_LO[0];
        end else begin
          period_next = vtb_pkg::SINK_PERIOD;
          on_next     = vtb_pkg::SINK_ON;
          run_div     = 1'b1;
          op_a        = a_sink;
          op_b        = b_sink;
          op_den      = den_sink;
          op_base     = max_freq >> 1;
        end
      end else if (is_climb) begin
        mode_next = vtb_pkg::MODE_CLIMB;
        if (climb_warble) begin
          period_next = vtb_pkg::WARBLE_TICKS;
          on_next     = vtb_pkg::WARBLE_TICKS;
          hz_next     = vtb_pkg::WARBLE_HI[0];
        end else begin
          period_next = vtb_pkg::CLIMB_PERIOD[climb_idx];
          on_next     = vtb_pkg::CLIMB_ON[climb_idx];
          run_div     = 1'b1;
          if (above_cross) begin
            op_a    = a_oct;
            op_b    = b_oct;
            op_den  = den_oct;
            op_base = crossover_freq;
          end
        end
      end else if (is_zeroes) begin
        mode_next   = vtb_pkg::MODE_ZEROES;
        period_next = vtb_pkg::ZEROES_PERIOD;
        on_next     = vtb_pkg::ZEROES_ON;
        run_div     = 1'b1;
      end else begin
        mode_next   = vtb_pkg::MODE_QUIET;
        period_next = '0;
        on_next     = '0;
      end
    end else begin
      // beep continues: mute after on-time, warble, or sink glide
      if (tick_next >= on_ticks) begin
        hz_next = '0;
      end else if (lat_hi_warble) begin
        hz_next = vtb_pkg::WARBLE_HI[tick_next[2:0]];
      end else if (lat_lo_warble) begin
        hz_next = vtb_pkg::WARBLE_LO[tick_next[2:0]];
      end else if (tone_mode == vtb_pkg::MODE_SINK) begin
        hz_next = (playing_hz >= vtb_pkg::SINK_FALL_HZ) ?
                  playing_hz - vtb_pkg::SINK_FALL_HZ : '0;
      end
      upd_next = (hz_next != playing_hz);
    end
  end

  assign md_req.start = (state == ST_EVAL) && run_div;
  assign md_req.a     = op_a;
  assign md_req.b     = op_b;
  assign md_req.den   = op_den;

  vtb_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // ------------------------------------------------------------------
  // base + quotient, then clamp: below min to min, else above max to max
  // ------------------------------------------------------------------
  logic signed [SumW-1:0] base_s, quot_s, sum_hz, min_s, max_s;
  logic [HzW-1:0]         clamped_hz;

  assign base_s = {{(SumW-HzW){1'b0}}, base_hz};
  assign quot_s = {md_rsp.quot[QuotW-1], md_rsp.quot};
  assign sum_hz = base_s + quot_s;
  assign min_s  = {{(SumW-HzW){1'b0}}, min_freq};
  assign max_s  = {{(SumW-HzW){1'b0}}, max_freq};

  always_comb begin
    if (sum_hz < min_s) begin
      clamped_hz = min_freq;
    end else if (sum_hz > max_s) begin
      clamped_hz = max_freq;
    end else begin
      clamped_hz = sum_hz[HzW-1:0];
    end
  end

  // ------------------------------------------------------------------
  // sequencer and state update
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      latched_rate <= '0;
      playing_hz   <= '0;
      period_left  <= '0;
      on_ticks     <= '0;
      tick_count   <= '0;
      tone_mode    <= vtb_pkg::MODE_QUIET;
      upd          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // output word leaves when taken
      if (out_valid && tone_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rate_in.valid) begin
            rate  <= rate_in.climb_rate_cps;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (start_beep) begin
            latched_rate <= rate;
          end
          period_left <= period_next;
          on_ticks    <= on_next;
          tick_count  <= tick_next;
          tone_mode   <= mode_next;
          playing_hz  <= hz_next;
          upd         <= upd_next;
          base_hz     <= op_base;
          state       <= (start_beep && run_div) ? ST_WAIT : ST_PUT;
        end
        ST_WAIT: begin
          if (md_rsp.done) begin
            playing_hz <= clamped_hz;
            state      <= ST_PUT;
          end
        end
        ST_PUT: begin
          // output register free, or emptied at this edge
          if (!out_valid || tone_out.ready) begin
            out_valid <= 1'b1;
            out_hz    <= playing_hz;
            out_upd   <= upd;
            out_mode  <= tone_mode;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rate_in.ready        = (state == ST_IDLE);
  assign tone_out.valid       = out_valid;
  assign tone_out.tone_hz     = out_hz;
  assign tone_out.tone_update = out_upd;
  assign tone_out.mode        = out_mode;

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  logic eval_start, quiet_word;
  assign eval_start = (state == ST_EVAL) && start_beep;
  assign quiet_word = tone_out.valid && (tone_out.mode == vtb_pkg::MODE_QUIET);

  `VTB_ASSERT_IMP(chk_done_in_wait, clk, rst, md_rsp.done, state == ST_WAIT)
  `VTB_ASSERT_NXT(chk_start_resets_tick, clk, rst, eval_start, (tick_count == '0) && upd)
  `VTB_ASSERT_IMP(chk_quiet_silent, clk, rst, quiet_word, tone_out.tone_hz == '0)

endmodule

`default_nettype wire
